FILE: hdl/stat_pkg.sv
// ----------------------------------------------------------------------------
// stat_pkg
// Shared types and constants of the sorted trap address table.
// ----------------------------------------------------------------------------
package stat_pkg;

  localparam int unsigned DefaultDepth       = 64;
  localparam int unsigned DefaultHandlerBits = 8;
  localparam int unsigned AddrBits           = 32;
  localparam int unsigned CmdBits            = 2;
  localparam int unsigned StatusBits         = 3;
  localparam int unsigned HandlerOutBits     = 8;
  localparam int unsigned HandlerInBits      = 8;
  localparam int unsigned CfgIndexBits       = 2;
  localparam int unsigned FifoDepth          = 2;

  typedef enum logic [CmdBits-1:0] {
    CMD_CLEAR    = 2'd0,
    CMD_REGISTER = 2'd1,
    CMD_LOOKUP   = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [StatusBits-1:0] {
    ST_OK       = 3'd0,
    ST_MISS     = 3'd1,
    ST_EXCLUDED = 3'd2,
    ST_FULL     = 3'd3,
    ST_REPLACED = 3'd4
  } status_t;

  typedef enum logic [CfgIndexBits-1:0] {
    REG_EXCL0_LOW  = 2'd0,
    REG_EXCL0_HIGH = 2'd1,
    REG_EXCL1_LOW  = 2'd2,
    REG_EXCL1_HIGH = 2'd3
  } reg_index_t;

  // Classified command handed from front to back.
  typedef struct packed {
    cmd_t                  command;
    logic                  excluded;
    logic [AddrBits-1:0]   address;
    logic [HandlerInBits-1:0] handler;
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROBE,
    S_CHECK,
    S_SHIFT,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

FILE: hdl/stat_front.sv
// ----------------------------------------------------------------------------
// stat_front
// Holds the exclusion registers, classifies commands and queues them.
// ----------------------------------------------------------------------------
module stat_front
  import stat_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  output logic                     full,
  input  logic [CmdBits-1:0]       command,
  input  logic [AddrBits-1:0]      address,
  input  logic [HandlerInBits-1:0] handler_in,
  input  logic                     cfg_write,
  input  logic [CfgIndexBits-1:0]  cfg_index,
  input  logic [AddrBits-1:0]      cfg_data,
  output logic                     op_valid,
  input  logic                     op_take,
  output op_t                      op
);

  logic [AddrBits-1:0] excl0_low, excl0_high, excl1_low, excl1_high;
  op_t                 fifo [FifoDepth];
  logic                wr_ptr, rd_ptr;
  logic [1:0]          fill;
  logic                in_excl;
  logic                do_push, do_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      excl0_low  <= '0;
      excl0_high <= '0;
      excl1_low  <= '0;
      excl1_high <= '0;
    end else if (cfg_write) begin
      unique case (reg_index_t'(cfg_index))
        REG_EXCL0_LOW:  excl0_low  <= cfg_data;
        REG_EXCL0_HIGH: excl0_high <= cfg_data;
        REG_EXCL1_LOW:  excl1_low  <= cfg_data;
        REG_EXCL1_HIGH: excl1_high <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_excl = (address >= excl0_low && address < excl0_high) ||
                   (address >= excl1_low && address < excl1_high);

  assign full     = fill == 2'd2;
  assign op_valid = fill != 2'd0;
  assign do_push  = push && !full;
  assign do_pop   = op_take && op_valid;
  assign op       = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      fifo[wr_ptr] <= '{command: cmd_t'(command), excluded: in_excl,
                        address: address, handler: handler_in};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

FILE: hdl/stat_back.sv
// ----------------------------------------------------------------------------
// stat_back
// Sorted table in memory: binary search, in-place insert, result register.
// ----------------------------------------------------------------------------
module stat_back
  import stat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = DefaultDepth,
  parameter int unsigned HANDLER_BITS = DefaultHandlerBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      op_valid,
  output logic                      op_take,
  input  op_t                       op,
  output logic                      empty,
  input  logic                      pop,
  output logic [StatusBits-1:0]     status,
  output logic [HandlerOutBits-1:0] handler_out
);

  localparam int unsigned IdxBits = $clog2(TABLE_DEPTH);
  localparam int unsigned CntBits = $clog2(TABLE_DEPTH + 1);

  typedef logic [AddrBits+HANDLER_BITS-1:0] word_t;

  word_t               mem [TABLE_DEPTH];
  word_t               rd_data;
  logic [IdxBits-1:0]  rd_addr;
  logic                wr_en;
  logic [IdxBits-1:0]  wr_addr;
  word_t               wr_data;

  state_t              state, state_next;
  op_t                 cur;
  logic [CntBits-1:0]  count;
  logic [CntBits-1:0]  lo, hi, mid, shift;
  logic                res_valid;
  status_t             res_status;
  logic [HANDLER_BITS-1:0] res_handler;
  logic                hit;
  logic                start;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end

  assign mid   = lo + ((hi - lo) >> 1);
  assign hit   = lo < count && rd_data[AddrBits+HANDLER_BITS-1:HANDLER_BITS] == cur.address;
  assign start = state == S_IDLE && op_valid && !res_valid;
  assign op_take = start;
  assign empty = !res_valid;
  assign status = res_status;
  assign handler_out = HandlerOutBits'(res_handler);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (start) begin
        priority if (op.command == CMD_REGISTER && !op.excluded) state_next = S_READ;
        else if (op.command == CMD_LOOKUP && !op.excluded && count != '0)
          state_next = S_READ;
        else state_next = S_DONE;
      end
      S_READ:  state_next = (lo < hi) ? S_PROBE : S_CHECK;
      S_PROBE: state_next = S_READ;
      S_CHECK: state_next = S_WRITE;
      S_WRITE: state_next = S_DONE;
      S_SHIFT: state_next = (shift == lo) ? S_WRITE : S_SHIFT;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
    if (state == S_CHECK) begin
      if (cur.command == CMD_LOOKUP || hit) state_next = (cur.command == CMD_LOOKUP)
                                                       ? S_DONE : S_WRITE;
      else if (count == CntBits'(TABLE_DEPTH)) state_next = S_DONE;
      else if (count == lo) state_next = S_WRITE;
      else state_next = S_SHIFT;
    end
  end

  // Memory port control: read address follows the search or shift cursor.
  always_comb begin
    rd_addr = IdxBits'(mid);
    wr_en   = 1'b0;
    wr_addr = IdxBits'(lo);
    wr_data = {cur.address, HANDLER_BITS'(cur.handler)};
    unique case (state)
      S_READ:  rd_addr = (lo < hi) ? IdxBits'(mid) : IdxBits'(lo);
      S_CHECK: rd_addr = IdxBits'(count - CntBits'(1));
      S_SHIFT: begin
        rd_addr = IdxBits'(shift - CntBits'(2));
        wr_en   = 1'b1;
        wr_addr = IdxBits'(shift);
        wr_data = rd_data;
      end
      S_WRITE: wr_en = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (res_valid && pop) res_valid <= 1'b0;
      if (state == S_DONE) res_valid <= 1'b1;
      if (start && op.command == CMD_CLEAR) count <= '0;
      if (state == S_WRITE && res_status == ST_OK) count <= count + CntBits'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: if (start) begin
        // a new command is taken only after the waiting result has been popped
        cur         <= op;
        lo          <= '0;
        hi          <= count;
        res_handler <= '0;
        priority if (op.command == CMD_CLEAR) res_status <= ST_OK;
        else if (op.command == CMD_LOOKUP && count == '0) res_status <= ST_MISS;
        else if ((op.command == CMD_REGISTER || op.command == CMD_LOOKUP) && op.excluded)
          res_status <= ST_EXCLUDED;
        else res_status <= ST_MISS;
      end
      S_PROBE: begin
        if (rd_data[AddrBits+HANDLER_BITS-1:HANDLER_BITS] < cur.address)
          lo <= mid + CntBits'(1);
        else hi <= mid;
      end
      S_CHECK: begin
        shift <= count;
        if (cur.command == CMD_LOOKUP) begin
          if (hit) begin
            res_status  <= ST_OK;
            res_handler <= rd_data[HANDLER_BITS-1:0];
          end
        end else if (hit) res_status <= ST_REPLACED;
        else if (count == CntBits'(TABLE_DEPTH)) res_status <= ST_FULL;
        else res_status <= ST_OK;
      end
      S_SHIFT: shift <= shift - CntBits'(1);
      default: ;
    endcase
  end

endmodule

FILE: hdl/sorted_trap_address_table.sv
// Sorted trap address table. Commands enter through a two-entry queue and
// are carried out one at a time against a table memory with one read and
// one write port. A clear, an unknown command or an excluded address goes
// straight to the result; a lookup does a binary search of the entries, and
// a register does the same search and then writes the entry unless the table
// is full; a register of a new address first moves every later entry up one
// place. The result sits in an output register, and the next command is
// taken from the queue only after that result has been transferred out.
// ----------------------------------------------------------------------------
// sorted_trap_address_table
// Top level: configuration, front classifier and back table engine.
// ----------------------------------------------------------------------------
module sorted_trap_address_table
  import stat_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = DefaultDepth,
  parameter int unsigned HANDLER_BITS = DefaultHandlerBits
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic [CmdBits-1:0]        command,
  input  logic [AddrBits-1:0]       address,
  input  logic [HandlerInBits-1:0]  handler_in,
  output logic                      empty,
  input  logic                      pop,
  output logic [StatusBits-1:0]     status,
  output logic [HandlerOutBits-1:0] handler_out,
  input  logic                      cfg_write,
  input  logic [CfgIndexBits-1:0]   cfg_index,
  input  logic [AddrBits-1:0]       cfg_data
);

  logic op_valid, op_take;
  op_t  op;

  stat_front u_front (
    .clk, .rst, .push, .full, .command, .address, .handler_in,
    .cfg_write, .cfg_index, .cfg_data, .op_valid, .op_take, .op
  );

  stat_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .HANDLER_BITS(HANDLER_BITS)
  ) u_back (
    .clk, .rst, .op_valid, .op_take, .op, .empty, .pop, .status, .handler_out
  );

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> status <= 3'(ST_REPLACED))
    else $error("status out of range");

  a_handler_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && status != 3'(ST_OK) |-> handler_out == '0)
    else $error("handler set on non-hit");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(status) && $stable(handler_out))
    else $error("result changed while waiting");

endmodule
